### src/cobs_pkg.sv
`timescale 1ns / 1ps

package cobs_pkg;

  localparam int FRAME_BYTES_W = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP      = 2'd2;

  localparam logic [7:0] CODE_NO_ZERO = 8'hFF;
  localparam logic [7:0] CODE_ZERO    = 8'h00;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRAME,
    MODE_DRAIN_CORRUPT,
    MODE_DRAIN_OVERSIZE
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_DONE,
    KIND_DECODE_ERR,
    KIND_OVERSIZE
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [7:0]               data;
    logic [FRAME_BYTES_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } cmd_t;

endpackage

### src/cobs_front.sv
`timescale 1ns / 1ps

module cobs_front #(
  parameter int FRAME_LEN_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cobs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cobs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_full,
  output logic                                 q_push,
  output cobs_pkg::cmd_t                       q_cmd
);

  localparam int LIM_W = (FRAME_LEN_BITS > 16) ? FRAME_LEN_BITS : 16;
  localparam logic [LIM_W-1:0] CAP = LIM_W'((64'd1 << FRAME_LEN_BITS) - 64'd1);

  logic [7:0]                delim_r;
  logic [15:0]               max_frame_r;
  logic                      drop_r;

  cobs_pkg::mode_t           mode_r, mode_nxt;
  logic [7:0]                run_left_r, run_left_nxt;
  logic                      zero_owed_r, zero_owed_nxt;
  logic [FRAME_LEN_BITS-1:0] frame_count_r, frame_count_nxt;

  logic                      fire;
  logic                      is_delim;
  logic [LIM_W-1:0]          max_ext;
  logic [LIM_W-1:0]          limit;
  logic                      at_limit;
  logic [FRAME_LEN_BITS-1:0] cnt_inc;
  logic                      data_path;
  logic                      frame_end;
  logic                      code_path;
  logic                      owe;
  logic                      zero_over;
  logic                      take;
  logic                      bad_code;
  logic                      has_result;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= 8'd0;
      max_frame_r <= 16'hFFFF;
      drop_r      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cobs_pkg::CFG_DELIMITER: delim_r     <= cfg_data[7:0];
        cobs_pkg::CFG_MAX_FRAME: max_frame_r <= cfg_data[15:0];
        cobs_pkg::CFG_DROP:      drop_r      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Classification of the incoming byte against the current decoder state.
  assign is_delim  = (in_data_byte == delim_r);
  assign max_ext   = LIM_W'(max_frame_r);
  assign limit     = (max_ext < CAP) ? max_ext : CAP;
  assign at_limit  = (LIM_W'(frame_count_r) >= limit);
  assign cnt_inc   = frame_count_r + FRAME_LEN_BITS'(1);
  assign data_path = (mode_r == cobs_pkg::MODE_FRAME) && (run_left_r != 8'd0);
  assign frame_end = (mode_r == cobs_pkg::MODE_FRAME) && (run_left_r == 8'd0) && is_delim;
  assign code_path = !is_delim && ((mode_r == cobs_pkg::MODE_IDLE) ||
                     ((mode_r == cobs_pkg::MODE_FRAME) && (run_left_r == 8'd0)));
  assign owe       = code_path && zero_owed_r;
  assign zero_over = owe && at_limit;
  assign take      = code_path && !zero_over;
  assign bad_code  = take && (in_data_byte == cobs_pkg::CODE_ZERO);
  assign has_result = data_path || frame_end || owe || bad_code;

  always_comb begin
    mode_nxt        = mode_r;
    run_left_nxt    = run_left_r;
    zero_owed_nxt   = zero_owed_r;
    frame_count_nxt = frame_count_r;
    case (mode_r)
      cobs_pkg::MODE_DRAIN_CORRUPT,
      cobs_pkg::MODE_DRAIN_OVERSIZE: begin
        if (is_delim) begin
          mode_nxt        = cobs_pkg::MODE_IDLE;
          run_left_nxt    = 8'd0;
          zero_owed_nxt   = 1'b0;
          frame_count_nxt = '0;
        end
      end
      default: begin
        if (data_path) begin
          if (at_limit) begin
            mode_nxt = cobs_pkg::MODE_DRAIN_OVERSIZE;
          end else begin
            frame_count_nxt = cnt_inc;
            run_left_nxt    = run_left_r - 8'd1;
          end
        end
        if (frame_end) begin
          mode_nxt        = cobs_pkg::MODE_IDLE;
          run_left_nxt    = 8'd0;
          zero_owed_nxt   = 1'b0;
          frame_count_nxt = '0;
        end
        if (zero_over) begin
          mode_nxt = cobs_pkg::MODE_DRAIN_OVERSIZE;
        end else if (owe) begin
          frame_count_nxt = cnt_inc;
          zero_owed_nxt   = 1'b0;
        end
        if (take) begin
          if (bad_code) begin
            if (drop_r) begin
              mode_nxt = cobs_pkg::MODE_DRAIN_CORRUPT;
            end else if (mode_r == cobs_pkg::MODE_FRAME) begin
              mode_nxt        = cobs_pkg::MODE_IDLE;
              run_left_nxt    = 8'd0;
              zero_owed_nxt   = 1'b0;
              frame_count_nxt = '0;
            end
          end else begin
            mode_nxt      = cobs_pkg::MODE_FRAME;
            run_left_nxt  = in_data_byte - 8'd1;
            zero_owed_nxt = (in_data_byte != cobs_pkg::CODE_NO_ZERO);
          end
        end
      end
    endcase
  end

  always_comb begin
    q_cmd = '0;
    q_push = fire && has_result;
    if (data_path) begin
      if (at_limit) begin
        q_cmd.first.kind  = cobs_pkg::KIND_OVERSIZE;
        q_cmd.first.count = cobs_pkg::FRAME_BYTES_W'(frame_count_r);
      end else begin
        q_cmd.first.kind  = cobs_pkg::KIND_BYTE;
        q_cmd.first.data  = in_data_byte;
        q_cmd.first.count = cobs_pkg::FRAME_BYTES_W'(cnt_inc);
      end
    end else if (frame_end) begin
      q_cmd.first.kind  = cobs_pkg::KIND_DONE;
      q_cmd.first.count = cobs_pkg::FRAME_BYTES_W'(frame_count_r);
    end else if (zero_over) begin
      q_cmd.first.kind  = cobs_pkg::KIND_OVERSIZE;
      q_cmd.first.count = cobs_pkg::FRAME_BYTES_W'(frame_count_r);
    end else if (owe) begin
      q_cmd.first.kind  = cobs_pkg::KIND_BYTE;
      q_cmd.first.count = cobs_pkg::FRAME_BYTES_W'(cnt_inc);
      if (bad_code) begin
        q_cmd.two          = 1'b1;
        q_cmd.second.kind  = cobs_pkg::KIND_DECODE_ERR;
        q_cmd.second.count = cobs_pkg::FRAME_BYTES_W'(cnt_inc);
      end
    end else if (bad_code) begin
      q_cmd.first.kind  = cobs_pkg::KIND_DECODE_ERR;
      q_cmd.first.count = cobs_pkg::FRAME_BYTES_W'(frame_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= cobs_pkg::MODE_IDLE;
      run_left_r    <= 8'd0;
      zero_owed_r   <= 1'b0;
      frame_count_r <= '0;
    end else if (fire) begin
      mode_r        <= mode_nxt;
      run_left_r    <= run_left_nxt;
      zero_owed_r   <= zero_owed_nxt;
      frame_count_r <= frame_count_nxt;
    end
  end

endmodule

### src/cobs_queue.sv
`timescale 1ns / 1ps

module cobs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cobs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cobs_pkg::cmd_t head
);

  localparam logic [cobs_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    cobs_pkg::QUEUE_PTR_W'(cobs_pkg::QUEUE_DEPTH - 1);
  localparam logic [cobs_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
    cobs_pkg::QUEUE_CNT_W'(cobs_pkg::QUEUE_DEPTH);

  cobs_pkg::cmd_t                   slot_r [cobs_pkg::QUEUE_DEPTH];
  logic [cobs_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cobs_pkg::QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cobs_pkg::QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count_r == DEPTH_CNT);
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + cobs_pkg::QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - cobs_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/cobs_back.sv
`timescale 1ns / 1ps

module cobs_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  cobs_pkg::cmd_t                       q_head,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_result_kind,
  output logic [7:0]                           out_decoded_byte,
  output logic [cobs_pkg::FRAME_BYTES_W-1:0]   out_frame_bytes,
  output logic                                 out_last_of_run
);

  logic             out_valid_r, out_valid_nxt;
  logic             phase_r, phase_nxt;
  cobs_pkg::result_t res_r;
  cobs_pkg::result_t sel;
  logic             last_r;
  logic             last_sel;
  logic             load;
  logic             take;

  assign load = !out_valid_r || out_ready;
  assign take = load && !q_empty;

  // A two-result entry stays at the head until its second result is loaded.
  always_comb begin
    q_pop     = 1'b0;
    phase_nxt = phase_r;
    sel       = q_head.first;
    last_sel  = 1'b1;
    if (take) begin
      if (phase_r) begin
        sel       = q_head.second;
        q_pop     = 1'b1;
        phase_nxt = 1'b0;
      end else if (q_head.two) begin
        last_sel  = 1'b0;
        phase_nxt = 1'b1;
      end else begin
        q_pop = 1'b1;
      end
    end
    out_valid_nxt = load ? take : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r  <= sel;
      last_r <= last_sel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = res_r.kind;
  assign out_decoded_byte = res_r.data;
  assign out_frame_bytes  = res_r.count;
  assign out_last_of_run  = last_r;

endmodule

### src/cobs_stream_decoder.sv
`timescale 1ns / 1ps

// Streaming COBS decoder. Encoded bytes enter on the in_ channel, one byte per
// transfer. Each byte causes zero, one or two results on the out_ channel: a
// decoded byte, a frame-complete marker, a decode error or an oversize error,
// each with the decoded frame length. out_last_of_run marks the final result
// caused by one input byte. The cfg_ channel writes the delimiter byte, the
// frame length limit and the drop-after-error mode; it is always ready.
// An input transfer is classified and the decoder state is updated in the
// cycle of the transfer; its results wait in a two-entry queue and leave
// through a registered output stage. The input sustains one byte per cycle
// while each byte causes at most one result and the receiver is ready; a
// byte with two results sends them through the output stage one at a time.
// When the receiver stalls, the queue fills and in_ready drops until an entry
// drains. Synchronous reset restores the register defaults, returns the
// decoder to idle and empties the queue and output.

module cobs_stream_decoder #(
  parameter int FRAME_LEN_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_result_kind,
  output logic [7:0]                           out_decoded_byte,
  output logic [cobs_pkg::FRAME_BYTES_W-1:0]   out_frame_bytes,
  output logic                                 out_last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cobs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cobs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  cobs_pkg::cmd_t q_cmd;
  cobs_pkg::cmd_t q_head;

  cobs_front #(
    .FRAME_LEN_BITS(FRAME_LEN_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  cobs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  cobs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_decoded_byte (out_decoded_byte),
    .out_frame_bytes  (out_frame_bytes),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
